// File: hw/rtl/nels_pkg.sv
package nels_pkg;

    localparam int CMD_W    = 2;
    localparam int ROLE_W   = 2;
    localparam int NODE_W   = 20;
    localparam int COORD_W  = 24;
    localparam int CFG_W    = 6;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 48;
    localparam int LEN_W    = 25;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 160;

    // shift-subtract steps for total / count
    localparam int DIV_STEPS = SUM_W;

    localparam logic [CFG_W-1:0] CFG_MAX_NET_RESET = 6'd32;

    localparam logic [CMD_W-1:0] CMD_PIN    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;

    localparam logic [ROLE_W-1:0] ROLE_SRC     = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_SRCSINK = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_SINK    = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [NODE_W-1:0]  node;
        logic [ROLE_W-1:0]  role;
    } pin_rec_t;

endpackage

// File: hw/rtl/nels_ram.sv
module nels_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/net_edge_length_stats.sv
// Manhattan edge-length statistics over placed nets. Pins of a net arrive as
// pin transfers (tuser = pin) and are written into a pin RAM; an end-of-net
// transfer walks every (driver, receiver) pair of the buffered net, one pair
// per cycle, and folds |dx|+|dy| into a saturating count and total plus a
// running max and min. Nets with more pins than max_net_size, or with more
// than MAX_PINS pins, add nothing. A report transfer emits one result with
// count, total, max, min, truncated average and an empty flag, then clears
// the statistics. An end-of-net transfer for a measured net keeps the input
// stalled through the pair walk over the two RAM read ports and the pipeline
// drain; a report with edges runs the shift-subtract divider before the result
// is offered, and one without edges skips it. The result waits in an output
// register, so pins keep flowing while it is held. max_net_size is written on
// the cfg channel; the user must write it only while the block is idle, which
// the block itself does not enforce.
module net_edge_length_stats
    import nels_pkg::*;
#(
    parameter int MAX_PINS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,   // max_net_size

    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] pin_role, [21:2] node_id, [45:22] pin_x, [69:46] pin_y, [71:70] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]     s_tuser,

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] edge_count, [79:32] total_length, [104:80] max_length,
    // [129:105] min_length, [154:130] avg_length, [159:155] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    // [0] no_edges
    output logic [0:0]           m_tuser
);

    localparam int AW   = $clog2(MAX_PINS);
    localparam int CW   = $clog2(MAX_PINS + 1);
    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;
    localparam int RW   = $bits(pin_rec_t);
    localparam int DCW  = $clog2(DIV_STEPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // ---------------------------------------------------------------
    // control
    // ---------------------------------------------------------------
    logic [1:0]        state_reg, state_next;
    logic [CFG_W-1:0]  max_net_reg;
    logic [CW-1:0]     pins_reg;
    logic              oversize_reg;
    logic [CW-1:0]     walk_n_reg;
    logic [AW-1:0]     idx_i_reg, idx_j_reg;

    logic              in_xfer, cmd_pin, cmd_end, cmd_report;
    logic              walk_busy, net_ok, ram_we;
    logic              last_j, last_i;
    pin_rec_t          wr_rec;

    assign cfg_ready = 1'b1;

    // pair pipeline valids: RAM read, abs stage, sum stage
    logic rd_v_reg, pv2_reg, pv3_reg;
    assign walk_busy = rd_v_reg | pv2_reg | pv3_reg;

    assign s_tready   = (state_reg == ST_IDLE) && !walk_busy;
    assign in_xfer    = s_tvalid && s_tready;
    assign cmd_pin    = in_xfer && (s_tuser == CMD_PIN);
    assign cmd_end    = in_xfer && (s_tuser == CMD_END);
    assign cmd_report = in_xfer && (s_tuser == CMD_REPORT);

    assign ram_we = cmd_pin && (pins_reg < CW'(MAX_PINS));

    assign wr_rec.role = s_tdata[1:0];
    assign wr_rec.node = s_tdata[21:2];
    assign wr_rec.x    = s_tdata[45:22];
    assign wr_rec.y    = s_tdata[69:46];

    // a net is measured only if it fit the buffer and the size limit
    assign net_ok = !oversize_reg && (pins_reg != '0) &&
                    (CMPW'(pins_reg) <= CMPW'(max_net_reg));

    assign last_j = ({1'b0, idx_j_reg} == (AW + 1)'(walk_n_reg - CW'(1)));
    assign last_i = ({1'b0, idx_i_reg} == (AW + 1)'(walk_n_reg - CW'(1)));

    // ---------------------------------------------------------------
    // pin RAMs: same contents, one read port walks drivers, one receivers
    // ---------------------------------------------------------------
    logic [RW-1:0] rd_a_data, rd_b_data;
    pin_rec_t      rec_a, rec_b;

    nels_ram #(.WIDTH(RW), .DEPTH(MAX_PINS)) u_ram_drv (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (pins_reg[AW-1:0]),
        .wr_data (wr_rec),
        .rd_addr (idx_i_reg),
        .rd_data (rd_a_data)
    );

    nels_ram #(.WIDTH(RW), .DEPTH(MAX_PINS)) u_ram_rcv (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (pins_reg[AW-1:0]),
        .wr_data (wr_rec),
        .rd_addr (idx_j_reg),
        .rd_data (rd_b_data)
    );

    assign rec_a = pin_rec_t'(rd_a_data);
    assign rec_b = pin_rec_t'(rd_b_data);

    // ---------------------------------------------------------------
    // pair pipeline
    // ---------------------------------------------------------------
    logic               pair_take;
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W-1:0] adx_reg, ady_reg;
    logic [LEN_W-1:0]   dist_reg;

    always_comb begin
        pair_take = rd_v_reg &&
                    (rec_a.role inside {ROLE_SRC, ROLE_SRCSINK}) &&
                    (rec_b.role inside {ROLE_SRCSINK, ROLE_SINK}) &&
                    !(rec_a.role == ROLE_SRCSINK && rec_b.role == ROLE_SRCSINK &&
                      rec_a.node == rec_b.node);
        dx = $signed({rec_a.x[COORD_W-1], rec_a.x}) - $signed({rec_b.x[COORD_W-1], rec_b.x});
        dy = $signed({rec_a.y[COORD_W-1], rec_a.y}) - $signed({rec_b.y[COORD_W-1], rec_b.y});
    end

    always_ff @(posedge aclk) begin
        adx_reg  <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady_reg  <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        dist_reg <= {1'b0, adx_reg} + {1'b0, ady_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
            pv2_reg  <= 1'b0;
            pv3_reg  <= 1'b0;
        end else begin
            rd_v_reg <= (state_reg == ST_WALK);
            pv2_reg  <= pair_take;
            pv3_reg  <= pv2_reg;
        end
    end

    // ---------------------------------------------------------------
    // statistics
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] count_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [LEN_W-1:0] max_reg, min_reg;
    logic [SUM_W:0]   sum_wide;

    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(dist_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= '1;
        end else if (cmd_report) begin
            count_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            min_reg   <= '1;
        end else if (pv3_reg) begin
            if (count_reg != '1) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            sum_reg <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            if (dist_reg > max_reg) begin
                max_reg <= dist_reg;
            end
            if (dist_reg < min_reg) begin
                min_reg <= dist_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // report snapshot and shift-subtract divider
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] snap_cnt_reg;
    logic [SUM_W-1:0] snap_sum_reg;
    logic [LEN_W-1:0] snap_max_reg, snap_min_reg;
    logic [SUM_W-1:0] quo_reg;
    logic [CNT_W-1:0] rem_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [CNT_W:0]   rem_shift;
    logic             rem_ge;
    logic [LEN_W-1:0] avg_val;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, snap_cnt_reg});
    // saturated totals can push the quotient past the max; clamp there
    assign avg_val   = (quo_reg > SUM_W'(snap_max_reg)) ? snap_max_reg : quo_reg[LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd_report) begin
            snap_cnt_reg <= count_reg;
            snap_sum_reg <= sum_reg;
            snap_max_reg <= max_reg;
            snap_min_reg <= min_reg;
            quo_reg      <= (count_reg == '0) ? '0 : sum_reg;
            rem_reg      <= '0;
            div_cnt_reg  <= '0;
        end else if (state_reg == ST_DIV) begin
            rem_reg     <= rem_ge ? CNT_W'(rem_shift - {1'b0, snap_cnt_reg})
                                  : rem_shift[CNT_W-1:0];
            quo_reg     <= {quo_reg[SUM_W-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + DCW'(1);
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    logic out_free;
    assign out_free = !m_tvalid || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_end && net_ok) begin
                    state_next = ST_WALK;
                end else if (cmd_report) begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_DIV;
                end
            end
            ST_WALK: begin
                if (last_j && last_i) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == DCW'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            max_net_reg  <= CFG_MAX_NET_RESET;
            pins_reg     <= '0;
            oversize_reg <= 1'b0;
            walk_n_reg   <= '0;
            idx_i_reg    <= '0;
            idx_j_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                max_net_reg <= cfg_data;
            end
            if (ram_we) begin
                pins_reg <= pins_reg + CW'(1);
            end else if (cmd_pin) begin
                oversize_reg <= 1'b1;
            end
            if (cmd_end) begin
                pins_reg     <= '0;
                oversize_reg <= 1'b0;
                walk_n_reg   <= pins_reg;
                idx_i_reg    <= '0;
                idx_j_reg    <= '0;
            end
            if (state_reg == ST_WALK) begin
                if (last_j) begin
                    idx_j_reg <= '0;
                    idx_i_reg <= idx_i_reg + AW'(1);
                end else begin
                    idx_j_reg <= idx_j_reg + AW'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] out_cnt_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic [LEN_W-1:0] out_max_reg, out_min_reg, out_avg_reg;
    logic             out_empty_reg;
    logic             m_tvalid_reg;
    logic             out_load;

    assign out_load = (state_reg == ST_DONE) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_cnt_reg   <= snap_cnt_reg;
            out_sum_reg   <= snap_sum_reg;
            out_max_reg   <= snap_max_reg;
            out_min_reg   <= snap_min_reg;
            out_avg_reg   <= avg_val;
            out_empty_reg <= (snap_cnt_reg == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, out_avg_reg, out_min_reg, out_max_reg, out_sum_reg, out_cnt_reg};
    assign m_tuser  = out_empty_reg;

`ifndef SYNTHESIS
    // the pin RAMs are never written while a net is being walked
    a_no_write_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK || walk_busy) |-> !ram_we)
        else $error("pin RAM written during pair walk");

    // walk indices stay inside the buffered net
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (CW'(idx_i_reg) < walk_n_reg && CW'(idx_j_reg) < walk_n_reg))
        else $error("pair walk index past net size");

    // empty statistics look cleared
    a_empty_stats: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (max_reg == '0 && min_reg == '1 && sum_reg == '0))
        else $error("statistics not clear with zero count");

    // with edges, min never exceeds max
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("min above max");

    // offered average never exceeds offered max
    a_avg_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_avg_reg <= out_max_reg))
        else $error("average above max");
`endif

endmodule

// File: tb/tb_net_edge_length_stats.sv
module tb_net_edge_length_stats;
    import nels_pkg::*;

    localparam int PIN_SLOTS    = 32;       // MAX_PINS of the instance
    localparam int WALK_CYCLES  = 1100;     // covers the worst pair walk plus margin
    localparam int DRAIN_CYCLES = 100;
    localparam int QUIET_LIMIT  = 20000;
    localparam int SHOWN_ERRORS = 10;

    localparam logic [CMD_W-1:0]  CMD_NONE  = 2'd3;   // unused command, ignored
    localparam logic [ROLE_W-1:0] ROLE_NONE = 2'd3;   // neither driver nor receiver

    localparam logic [LEN_W-1:0]  LEN_ALL_ONES = {LEN_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_ALL_ONES = {CNT_W{1'b1}};
    localparam longint unsigned   SUM_ALL_ONES = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct {
        logic [CNT_W-1:0] edges;
        logic [SUM_W-1:0] total;
        logic [LEN_W-1:0] longest;
        logic [LEN_W-1:0] shortest;
        logic [LEN_W-1:0] mean;
        logic             empty;
    } net_report_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    net_edge_length_stats u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // idling percentages, changed between phases
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int error_count  = 0;
    int quiet_cycles = 0;

    // expected reports, oldest first
    net_report_t pending_reports[$];

    // ---- edge-length predictor ----
    int               pin_xs[PIN_SLOTS];
    int               pin_ys[PIN_SLOTS];
    logic [ROLE_W-1:0] pin_roles[PIN_SLOTS];
    logic [NODE_W-1:0] pin_nodes[PIN_SLOTS];
    int               net_pins      = 0;
    bit               net_overflow  = 1'b0;
    int               net_size_cap  = 32;
    logic [CNT_W-1:0] stat_edges    = '0;
    longint unsigned  stat_sum      = 0;
    logic [LEN_W-1:0] stat_max      = '0;
    logic [LEN_W-1:0] stat_min      = LEN_ALL_ONES;

    function automatic int unsigned span(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void walk_net_pairs();
        int          i;
        int          j;
        int unsigned d;
        if (net_overflow || net_pins > net_size_cap) return;
        for (i = 0; i < net_pins; i++) begin
            if (pin_roles[i] != ROLE_SRC && pin_roles[i] != ROLE_SRCSINK) continue;
            for (j = 0; j < net_pins; j++) begin
                if (pin_roles[j] != ROLE_SRCSINK && pin_roles[j] != ROLE_SINK) continue;
                // a source-sink never drives itself
                if (pin_roles[i] == ROLE_SRCSINK && pin_roles[j] == ROLE_SRCSINK &&
                    pin_nodes[i] == pin_nodes[j]) continue;
                d = span(pin_xs[i], pin_xs[j]) + span(pin_ys[i], pin_ys[j]);
                if (stat_edges != CNT_ALL_ONES) stat_edges++;
                stat_sum += d;
                if (stat_sum > SUM_ALL_ONES) stat_sum = SUM_ALL_ONES;
                if (d > stat_max) stat_max = LEN_W'(d);
                if (d < stat_min) stat_min = LEN_W'(d);
            end
        end
    endfunction

    function automatic void predict_transfer(input logic [CMD_W-1:0] cmd,
                                             input pin_rec_t pin);
        net_report_t     rep;
        longint unsigned avg;
        case (cmd)
            CMD_PIN: begin
                if (net_pins < PIN_SLOTS) begin
                    pin_roles[net_pins] = pin.role;
                    pin_nodes[net_pins] = pin.node;
                    pin_xs[net_pins]    = int'($signed(pin.x));
                    pin_ys[net_pins]    = int'($signed(pin.y));
                    net_pins++;
                end else begin
                    net_overflow = 1'b1;
                end
            end
            CMD_END: begin
                walk_net_pairs();
                net_pins     = 0;
                net_overflow = 1'b0;
            end
            CMD_REPORT: begin
                avg = 0;
                if (stat_edges != 0) begin
                    avg = stat_sum / stat_edges;
                    if (avg > stat_max) avg = stat_max;
                end
                rep.edges    = stat_edges;
                rep.total    = SUM_W'(stat_sum);
                rep.longest  = stat_max;
                rep.shortest = stat_min;
                rep.mean     = LEN_W'(avg);
                rep.empty    = (stat_edges == 0);
                pending_reports.push_back(rep);
                stat_edges = '0;
                stat_sum   = 0;
                stat_max   = '0;
                stat_min   = LEN_ALL_ONES;
            end
            default: ;
        endcase
    endfunction

    // ---- result checking and receiver stalls ----
    function automatic void check_report(input logic [M_TDATA_W-1:0] data,
                                         input logic flag);
        net_report_t want;
        net_report_t got;
        got.edges    = data[31:0];
        got.total    = data[79:32];
        got.longest  = data[104:80];
        got.shortest = data[129:105];
        got.mean     = data[154:130];
        got.empty    = flag;
        if (pending_reports.size() == 0) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS)
                $display("unexpected report: cnt=%0d sum=%0d", got.edges, got.total);
            return;
        end
        want = pending_reports.pop_front();
        if (got.edges !== want.edges || got.total !== want.total ||
            got.longest !== want.longest || got.shortest !== want.shortest ||
            got.mean !== want.mean || got.empty !== want.empty) begin
            error_count++;
            if (error_count <= SHOWN_ERRORS) begin
                $display("report mismatch: exp cnt=%0d sum=%0d max=%0d min=%0d avg=%0d empty=%0d",
                         want.edges, want.total, want.longest, want.shortest,
                         want.mean, want.empty);
                $display("                 got cnt=%0d sum=%0d max=%0d min=%0d avg=%0d empty=%0d",
                         got.edges, got.total, got.longest, got.shortest,
                         got.mean, got.empty);
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_report(m_tdata, m_tuser[0]);
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transfer in %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---- stimulus helpers ----
    task automatic push_transfer(input logic [CMD_W-1:0] cmd, input pin_rec_t pin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, pin};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_transfer(cmd, pin);
    endtask

    task automatic wait_reports_drained();
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic write_net_size_cap(input logic [CFG_W-1:0] cap);
        s_tvalid <= 1'b0;
        wait_reports_drained();
        // an end of net may still be walking pairs
        repeat (WALK_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid    <= 1'b0;
        net_size_cap = cap;
    endtask

    function automatic pin_rec_t make_pin(input logic [ROLE_W-1:0] role,
                                          input logic [NODE_W-1:0] node,
                                          input int x, input int y);
        pin_rec_t p;
        p.role = role;
        p.node = node;
        p.x    = COORD_W'(x);
        p.y    = COORD_W'(y);
        return p;
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 9))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            2, 3, 4: return COORD_W'($urandom);
            default: return COORD_W'($urandom_range(0, 127) - 64);
        endcase
    endfunction

    function automatic pin_rec_t random_pin();
        pin_rec_t p;
        int       r;
        r = $urandom_range(0, 19);
        p.role = (r < 6) ? ROLE_SRC : (r < 12) ? ROLE_SRCSINK :
                 (r < 19) ? ROLE_SINK : ROLE_NONE;
        // small node pool makes same-node source-sinks common
        p.node = $urandom_range(0, 1) ? NODE_W'($urandom_range(0, 3)) : NODE_W'($urandom);
        p.x    = random_coord();
        p.y    = random_coord();
        return p;
    endfunction

    function automatic int random_net_size();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 4)  return 0;
        if (r < 70) return $urandom_range(1, 6);
        if (r < 82) begin
            n = net_size_cap + $urandom_range(0, 1);    // at or just past the size limit
            return (n < 1) ? 1 : (n > 36) ? 36 : n;
        end
        if (r < 94) return $urandom_range(7, 32);
        return $urandom_range(33, 36);                  // overflows the pin buffer
    endfunction

    task automatic run_random_nets(input int n_items, input int n_reports);
        int items;
        int reports;
        int npins;
        int k;
        items   = 0;
        reports = 0;
        while (items < n_items || reports < n_reports) begin
            npins = random_net_size();
            for (k = 0; k < npins; k++) begin
                if ($urandom_range(0, 39) == 0) push_transfer(CMD_NONE, random_pin());
                if ($urandom_range(0, 59) == 0) begin
                    // report in the middle of a net, pins stay buffered
                    push_transfer(CMD_REPORT, random_pin());
                    reports++;
                    items++;
                end
                push_transfer(CMD_PIN, random_pin());
                items++;
            end
            push_transfer(CMD_END, random_pin());
            items++;
            if ($urandom_range(0, 1) == 0) begin
                push_transfer(CMD_REPORT, random_pin());
                reports++;
                items++;
            end
        end
        push_transfer(CMD_REPORT, random_pin());
    endtask

    // ---- tests ----
    task automatic test_empty_report();
        push_transfer(CMD_REPORT, random_pin());
    endtask

    task automatic test_pair_rules();
        push_transfer(CMD_PIN, make_pin(ROLE_SRC, 20'd5, -8388608, -8388608));
        push_transfer(CMD_PIN, make_pin(ROLE_SINK, 20'd6, 8388607, 8388607));
        push_transfer(CMD_PIN, make_pin(ROLE_SRCSINK, 20'd7, 0, 0));
        push_transfer(CMD_PIN, make_pin(ROLE_SRCSINK, 20'd7, 3, -4));
        push_transfer(CMD_PIN, make_pin(ROLE_SRCSINK, 20'd9, 10, 10));
        push_transfer(CMD_PIN, make_pin(ROLE_NONE, 20'd7, 100, 100));
        push_transfer(CMD_PIN, make_pin(ROLE_SINK, 20'hFFFFF, -1, 1));
        push_transfer(CMD_END, random_pin());
        push_transfer(CMD_NONE, random_pin());
        push_transfer(CMD_END, random_pin());           // net with no pins
        push_transfer(CMD_REPORT, random_pin());
        push_transfer(CMD_REPORT, random_pin());        // cleared, reads empty
    endtask

    task automatic test_size_limit();
        write_net_size_cap(6'd2);
        push_transfer(CMD_PIN, make_pin(ROLE_SRC, 20'd1, 5, 5));
        push_transfer(CMD_PIN, make_pin(ROLE_SINK, 20'd2, -5, 7));
        push_transfer(CMD_END, random_pin());
        push_transfer(CMD_PIN, make_pin(ROLE_SRC, 20'd1, 5, 5));
        push_transfer(CMD_PIN, make_pin(ROLE_SINK, 20'd2, -5, 7));
        push_transfer(CMD_PIN, make_pin(ROLE_SINK, 20'd3, 9, 9));
        push_transfer(CMD_END, random_pin());           // one pin too many, skipped
        push_transfer(CMD_REPORT, random_pin());
    endtask

    task automatic test_random_phase(input int send_pct, input int stall_pct,
                                     input logic [CFG_W-1:0] cap_a,
                                     input logic [CFG_W-1:0] cap_b);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        write_net_size_cap(cap_a);
        run_random_nets(65, 4);
        write_net_size_cap(cap_b);
        run_random_nets(65, 4);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_report();
        test_pair_rules();
        test_size_limit();

        test_random_phase(0, 0, 6'd32, 6'd1);
        test_random_phase(56, 0, 6'd0, 6'd63);
        test_random_phase(0, 56, CFG_W'($urandom_range(1, 32)), 6'd32);
        test_random_phase(20, 20, 6'd63, CFG_W'($urandom_range(1, 32)));

        s_tvalid <= 1'b0;
        wait_reports_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
